/* hdl/i2crtc_pkg.sv */
`default_nettype none

package i2crtc_pkg;

  // bus event codes
  localparam logic [2:0] OP_START    = 3'd0;
  localparam logic [2:0] OP_STOP     = 3'd1;
  localparam logic [2:0] OP_ADDR_WR  = 3'd2;
  localparam logic [2:0] OP_ADDR_RD  = 3'd3;
  localparam logic [2:0] OP_DATA_WR  = 3'd4;
  localparam logic [2:0] OP_DATA_RD  = 3'd5;
  localparam logic [2:0] OP_ACK      = 3'd6;
  localparam logic [2:0] OP_NACK     = 3'd7;

  // record kinds
  localparam logic [3:0] REC_SELECT    = 4'd0;
  localparam logic [3:0] REC_FIELD     = 4'd1;
  localparam logic [3:0] REC_DT_WR     = 4'd2;
  localparam logic [3:0] REC_DT_RD     = 4'd3;
  localparam logic [3:0] REC_AL1_WR    = 4'd4;
  localparam logic [3:0] REC_AL1_RD    = 4'd5;
  localparam logic [3:0] REC_AL2_WR    = 4'd6;
  localparam logic [3:0] REC_AL2_RD    = 4'd7;
  localparam logic [3:0] REC_TEMP_INT  = 4'd8;
  localparam logic [3:0] REC_TEMP_FRAC = 4'd9;

  // clock chip register map
  localparam logic [7:0] REG_SECONDS  = 8'd0;
  localparam logic [7:0] REG_MINUTES  = 8'd1;
  localparam logic [7:0] REG_HOURS    = 8'd2;
  localparam logic [7:0] REG_DAY      = 8'd3;
  localparam logic [7:0] REG_DATE     = 8'd4;
  localparam logic [7:0] REG_MONTH    = 8'd5;
  localparam logic [7:0] REG_YEAR     = 8'd6;
  localparam logic [7:0] REG_A1_SEC   = 8'd7;
  localparam logic [7:0] REG_A1_MIN   = 8'd8;
  localparam logic [7:0] REG_A1_HOUR  = 8'd9;
  localparam logic [7:0] REG_A1_DAY   = 8'd10;
  localparam logic [7:0] REG_A2_MIN   = 8'd11;
  localparam logic [7:0] REG_A2_HOUR  = 8'd12;
  localparam logic [7:0] REG_A2_DAY   = 8'd13;
  localparam logic [7:0] REG_CONTROL  = 8'd14;
  localparam logic [7:0] REG_STATUS   = 8'd15;
  localparam logic [7:0] REG_AGING    = 8'd16;
  localparam logic [7:0] REG_TEMP_MSB = 8'd17;
  localparam logic [7:0] REG_TEMP_LSB = 8'd18;

  // configuration register indexes
  localparam logic CFG_DAY_OFFSET = 1'b0;
  localparam logic CFG_DEV_ADDR   = 1'b1;

  localparam logic [6:0]  DEV_ADDR_RST = 7'h68;
  localparam logic [12:0] YEAR_BASE    = 13'd2000;

  // result tdata layout
  localparam int OFS_REG   = 0;
  localparam int OFS_DVAL  = 8;
  localparam int OFS_FLAGS = 17;
  localparam int OFS_SEC   = 25;
  localparam int OFS_MIN   = 33;
  localparam int OFS_HOUR  = 41;
  localparam int OFS_WDAY  = 48;
  localparam int OFS_DOM   = 51;
  localparam int OFS_MONTH = 58;
  localparam int OFS_YEAR  = 64;
  localparam int OFS_TEMP  = 77;
  localparam int OUT_USED_W = 93;
  localparam int OUT_DATA_W = 96;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [3:0]         kind;
    logic [7:0]         reg_idx;
    logic signed [8:0]  dval;
    logic [7:0]         flags;
    logic signed [7:0]  seconds;
    logic signed [7:0]  minutes;
    logic signed [6:0]  hours;
    logic [2:0]         weekday;
    logic signed [6:0]  dom;
    logic signed [5:0]  month;
    logic signed [12:0] year;
    logic signed [15:0] temp;
  } rec_t;

  function automatic logic [7:0] bcd(input logic [7:0] b);
    return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
  endfunction

  // 8 = 1 mod 7, so fold octal digits and fix up once
  function automatic logic [2:0] mod7(input logic [6:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = {1'b0, x[6:3]} + {2'b00, x[2:0]};
    s2 = {2'b00, s1[4:3]} + {1'b0, s1[2:0]};
    if (s2 >= 4'd7) s2 = s2 - 4'd7;
    return s2[2:0];
  endfunction

  function automatic logic [2:0] wday(input logic [5:0] n, input logic [2:0] off);
    return mod7({1'b0, n} + {4'b0000, off});
  endfunction

endpackage

`default_nettype wire

/* hdl/i2crtc_ingress.sv */
`default_nettype none

module i2crtc_ingress
  import i2crtc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  eg_ready,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  take;

  assign in_ready   = !valid_r || eg_ready;
  assign take       = in_valid && in_ready;
  assign item_valid = valid_r && eg_ready;
  assign item       = item_r;
  assign valid_nxt  = take || (valid_r && !eg_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

/* hdl/i2crtc_field.sv */
`default_nettype none

module i2crtc_field
  import i2crtc_pkg::*;
(
  input  wire logic [7:0] reg_idx,
  input  wire logic [7:0] b,
  input  wire logic [2:0] day_off,
  output logic signed [8:0] val,
  output logic [7:0]        flags
);

  always_comb begin
    val   = '0;
    flags = '0;
    unique case (reg_idx)
      REG_SECONDS, REG_MINUTES, REG_A1_SEC, REG_A1_MIN, REG_A2_MIN: begin
        val   = {1'b0, bcd(b & 8'h7f)};
        flags = b & 8'h80;
      end
      REG_HOURS, REG_A1_HOUR, REG_A2_HOUR: begin
        if (b[6]) begin
          // 12h mode
          val   = {1'b0, bcd(b & 8'h1f)};
          flags = b & 8'he0;
        end else begin
          val   = {1'b0, bcd(b & 8'h3f)};
          flags = b & 8'hc0;
        end
      end
      REG_DAY: begin
        val   = (b[2:0] == 3'd0) ? '1 : {6'd0, wday({3'd0, b[2:0]}, day_off)};
        flags = b & 8'hf8;
      end
      REG_DATE: begin
        val   = {1'b0, bcd(b & 8'h3f)};
        flags = b & 8'hc0;
      end
      REG_MONTH: begin
        val   = {1'b0, bcd(b & 8'h1f)};
        flags = b & 8'he0;
      end
      REG_YEAR: begin
        val = {1'b0, bcd(b)};
      end
      REG_A1_DAY, REG_A2_DAY: begin
        flags = b & 8'hc0;
        val   = b[6] ? {6'd0, wday(b[5:0], day_off)} : {1'b0, bcd(b & 8'h3f)};
      end
      REG_CONTROL, REG_STATUS: begin
        flags = b;
      end
      REG_AGING, REG_TEMP_MSB: begin
        val = {b[7], b};
      end
      REG_TEMP_LSB: begin
        val = {1'b0, b};
      end
      default: begin
        val   = '0;
        flags = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/i2crtc_core.sv */
`default_nettype none

module i2crtc_core
  import i2crtc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [6:0] cfg_wdata,
  input  wire logic       item_valid,
  input  wire item_t      item,
  output logic            res_valid,
  output rec_t            res
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_ADDR  = 3'd1;
  localparam logic [2:0] PH_SEL   = 3'd2;
  localparam logic [2:0] PH_WRITE = 3'd3;
  localparam logic [2:0] PH_READ  = 3'd4;

  logic [2:0] day_off_r;
  logic [6:0] dev_r;

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] ptr_r, ptr_nxt;
  logic       blk_r, blk_nxt;

  logic [6:0] ts_set_r, ts_set_nxt;
  logic [7:0] ts_val_r [7];
  logic [7:0] ts_val_nxt [7];
  logic [7:0] tint_r, tint_nxt;
  logic [7:0] tfrac_r, tfrac_nxt;

  logic       as_v_r, as_v_nxt, as_ign_r, as_ign_nxt;
  logic [6:0] as_val_r, as_val_nxt;
  logic       am_v_r, am_v_nxt, am_ign_r, am_ign_nxt;
  logic [6:0] am_val_r, am_val_nxt;
  logic       ah_v_r, ah_v_nxt, ah_12_r, ah_12_nxt, ah_pm_r, ah_pm_nxt;
  logic [5:0] ah_val_r, ah_val_nxt;
  logic       ad_v_r, ad_v_nxt, ad_ign_r, ad_ign_nxt, ad_dm_r, ad_dm_nxt;
  logic [5:0] ad_val_r, ad_val_nxt;

  logic [2:0]        op;
  logic [7:0]        b;
  logic signed [8:0] fval;
  logic [7:0]        fflags;
  logic              data_en;
  rec_t              base_rec, dt_rec, al_rec, tmp_rec;

  assign op = item.op;
  assign b  = item.data_byte;

  i2crtc_field u_field (
    .reg_idx (ptr_r),
    .b       (b),
    .day_off (day_off_r),
    .val     (fval),
    .flags   (fflags)
  );

  // record templates built from the shadows
  always_comb begin
    base_rec         = '0;
    base_rec.reg_idx = ptr_r;

    dt_rec         = base_rec;
    dt_rec.seconds = ts_set_r[0] ? $signed(ts_val_r[0]) : '1;
    dt_rec.minutes = ts_set_r[1] ? $signed(ts_val_r[1]) : '1;
    dt_rec.hours   = ts_set_r[2] ? $signed(ts_val_r[2][6:0]) : '1;
    dt_rec.weekday = wday(ts_val_r[3][5:0], day_off_r);
    dt_rec.dom     = ts_set_r[4] ? $signed(ts_val_r[4][6:0]) : '1;
    dt_rec.month   = ts_set_r[5] ? $signed(ts_val_r[5][5:0]) : '1;
    dt_rec.year    = ts_set_r[6] ? $signed({5'd0, ts_val_r[6]} + YEAR_BASE) : '1;

    // alarm 1 form; alarm 2 drops the seconds part
    al_rec         = base_rec;
    al_rec.flags   = {2'b00, ah_pm_r, ah_12_r, ad_dm_r, ad_ign_r, am_ign_r, as_ign_r};
    al_rec.seconds = as_v_r ? $signed({1'b0, as_val_r}) : '1;
    al_rec.minutes = am_v_r ? $signed({1'b0, am_val_r}) : '1;
    al_rec.hours   = ah_v_r ? $signed({1'b0, ah_val_r}) : '1;
    if (ad_v_r && ad_dm_r) begin
      al_rec.weekday = ad_val_r[2:0];
      al_rec.dom     = '1;
    end else begin
      al_rec.dom = ad_v_r ? $signed({1'b0, ad_val_r}) : '1;
    end

    tmp_rec      = base_rec;
    tmp_rec.temp = $signed({tint_r, 8'h00});
    tmp_rec.dval = $signed({tint_r[7], tint_r});
  end

  always_comb begin
    phase_nxt  = phase_r;
    ptr_nxt    = ptr_r;
    blk_nxt    = blk_r;
    ts_set_nxt = ts_set_r;
    ts_val_nxt = ts_val_r;
    tint_nxt   = tint_r;
    tfrac_nxt  = tfrac_r;
    as_v_nxt   = as_v_r;   as_ign_nxt = as_ign_r; as_val_nxt = as_val_r;
    am_v_nxt   = am_v_r;   am_ign_nxt = am_ign_r; am_val_nxt = am_val_r;
    ah_v_nxt   = ah_v_r;   ah_12_nxt  = ah_12_r;  ah_pm_nxt  = ah_pm_r;
    ah_val_nxt = ah_val_r;
    ad_v_nxt   = ad_v_r;   ad_ign_nxt = ad_ign_r; ad_dm_nxt  = ad_dm_r;
    ad_val_nxt = ad_val_r;
    data_en    = 1'b0;
    res_valid  = 1'b0;
    res        = base_rec;

    if (item_valid) begin
      priority if (op == OP_STOP) begin
        phase_nxt = PH_IDLE;
        blk_nxt   = 1'b0;
      end else if (op == OP_START) begin
        phase_nxt = PH_ADDR;
      end else begin
        unique case (phase_r)
          PH_ADDR: begin
            priority if (b != {1'b0, dev_r}) phase_nxt = PH_IDLE;
            else if (op == OP_ADDR_WR) phase_nxt = PH_SEL;
            else if (op == OP_ADDR_RD) phase_nxt = PH_READ;
            else phase_nxt = PH_ADDR;
          end
          PH_SEL: begin
            if (op == OP_DATA_WR) begin
              ptr_nxt       = b;
              phase_nxt     = PH_WRITE;
              res_valid     = 1'b1;
              res.kind      = REC_SELECT;
              res.reg_idx   = b;
            end else if (op == OP_NACK) begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_WRITE: begin
            if (op == OP_DATA_WR) begin
              if (ptr_r == REG_SECONDS || ptr_r == REG_A1_SEC || ptr_r == REG_A2_MIN)
                blk_nxt = 1'b1;
              data_en = 1'b1;
            end else if (op == OP_ACK && blk_r) begin
              priority if (ptr_r == REG_A1_SEC && ts_set_r[3] && ts_val_r[3] != 8'd0) begin
                res_valid = 1'b1;
                res       = dt_rec;
                res.kind  = REC_DT_WR;
              end else if (ptr_r == REG_A2_MIN) begin
                res_valid = 1'b1;
                res       = al_rec;
                res.kind  = REC_AL1_WR;
              end else if (ptr_r == REG_CONTROL) begin
                res_valid      = 1'b1;
                res            = al_rec;
                res.kind       = REC_AL2_WR;
                res.seconds    = '0;
                res.flags[0]   = 1'b0;
              end
            end
          end
          PH_READ: begin
            if (op == OP_DATA_RD) begin
              if (ptr_r == REG_SECONDS || ptr_r == REG_A1_SEC || ptr_r == REG_A2_MIN ||
                  ptr_r == REG_TEMP_MSB)
                blk_nxt = 1'b1;
              data_en = 1'b1;
            end else if (op == OP_NACK && blk_r) begin
              priority if (ptr_r == REG_A1_SEC && ts_set_r[3] && ts_val_r[3] != 8'd0) begin
                res_valid = 1'b1;
                res       = dt_rec;
                res.kind  = REC_DT_RD;
              end else if (ptr_r == REG_A2_MIN) begin
                res_valid = 1'b1;
                res       = al_rec;
                res.kind  = REC_AL1_RD;
              end else if (ptr_r == REG_CONTROL) begin
                res_valid    = 1'b1;
                res          = al_rec;
                res.kind     = REC_AL2_RD;
                res.seconds  = '0;
                res.flags[0] = 1'b0;
              end else if (ptr_r == REG_TEMP_LSB) begin
                res_valid = 1'b1;
                res       = tmp_rec;
                res.kind  = REC_TEMP_INT;
              end else if (ptr_r == REG_SECONDS) begin
                res_valid = 1'b1;
                res       = tmp_rec;
                res.kind  = REC_TEMP_FRAC;
                res.dval  = $signed({1'b0, tfrac_r});
                res.temp  = $signed({tint_r, tfrac_r});
              end
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end

    // data byte: decode into shadows and advance the pointer; a byte past the map only resets it
    if (data_en) begin
      if (ptr_r > REG_TEMP_LSB) begin
        ptr_nxt = '0;
      end else begin
        res_valid   = 1'b1;
        res         = base_rec;
        res.kind    = REC_FIELD;
        res.dval    = fval;
        res.flags   = fflags;
        ptr_nxt     = (ptr_r == REG_TEMP_LSB) ? 8'd0 : ptr_r + 8'd1;
        if (ptr_r <= REG_YEAR) begin
          ts_set_nxt[ptr_r[2:0]] = 1'b1;
          ts_val_nxt[ptr_r[2:0]] = (ptr_r == REG_DAY) ? {5'd0, b[2:0]} : fval[7:0];
        end
        unique case (ptr_r)
          REG_A1_SEC: begin
            as_v_nxt   = 1'b1;
            as_ign_nxt = b[7];
            as_val_nxt = fval[6:0];
          end
          REG_A1_MIN, REG_A2_MIN: begin
            am_v_nxt   = 1'b1;
            am_ign_nxt = b[7];
            am_val_nxt = fval[6:0];
          end
          REG_A1_HOUR, REG_A2_HOUR: begin
            if (b[6]) begin
              if (!b[7]) begin
                ah_v_nxt   = 1'b1;
                ah_val_nxt = fval[5:0];
                ah_12_nxt  = 1'b1;
                ah_pm_nxt  = b[5];
              end
            end else begin
              // 24h mode clears 12h and pm even when the hour is ignored
              ah_12_nxt = 1'b0;
              ah_pm_nxt = 1'b0;
              if (!b[7]) begin
                ah_v_nxt   = 1'b1;
                ah_val_nxt = fval[5:0];
              end
            end
          end
          REG_A1_DAY, REG_A2_DAY: begin
            ad_dm_nxt  = b[6];
            ad_v_nxt   = 1'b1;
            ad_ign_nxt = b[7];
            ad_val_nxt = fval[5:0];
          end
          REG_TEMP_MSB: tint_nxt  = b;
          REG_TEMP_LSB: tfrac_nxt = b;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_off_r <= '0;
      dev_r     <= DEV_ADDR_RST;
      phase_r   <= PH_IDLE;
      ptr_r     <= '0;
      blk_r     <= 1'b0;
      ts_set_r  <= '0;
      tint_r    <= '0;
      tfrac_r   <= '0;
      as_v_r    <= 1'b0;
      as_ign_r  <= 1'b0;
      am_v_r    <= 1'b0;
      am_ign_r  <= 1'b0;
      ah_v_r    <= 1'b0;
      ah_12_r   <= 1'b0;
      ah_pm_r   <= 1'b0;
      ad_v_r    <= 1'b0;
      ad_ign_r  <= 1'b0;
      ad_dm_r   <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_DAY_OFFSET) day_off_r <= cfg_wdata[2:0];
      if (cfg_we && cfg_index == CFG_DEV_ADDR)   dev_r     <= cfg_wdata;
      phase_r  <= phase_nxt;
      ptr_r    <= ptr_nxt;
      blk_r    <= blk_nxt;
      ts_set_r <= ts_set_nxt;
      tint_r   <= tint_nxt;
      tfrac_r  <= tfrac_nxt;
      as_v_r   <= as_v_nxt;
      as_ign_r <= as_ign_nxt;
      am_v_r   <= am_v_nxt;
      am_ign_r <= am_ign_nxt;
      ah_v_r   <= ah_v_nxt;
      ah_12_r  <= ah_12_nxt;
      ah_pm_r  <= ah_pm_nxt;
      ad_v_r   <= ad_v_nxt;
      ad_ign_r <= ad_ign_nxt;
      ad_dm_r  <= ad_dm_nxt;
    end
  end

  // shadow values, qualified by their set/valid bits
  always_ff @(posedge clk) begin
    ts_val_r <= ts_val_nxt;
    as_val_r <= as_val_nxt;
    am_val_r <= am_val_nxt;
    ah_val_r <= ah_val_nxt;
    ad_val_r <= ad_val_nxt;
  end

endmodule

`default_nettype wire

/* hdl/i2crtc_egress.sv */
`default_nettype none

module i2crtc_egress
  import i2crtc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  input  wire rec_t push_rec,
  output logic      ready,
  output logic      out_valid,
  output rec_t      out_rec,
  input  wire logic out_ready
);

  logic head_v_r, head_v_nxt;
  logic skid_v_r, skid_v_nxt;
  rec_t head_r, skid_r;
  logic head_free;
  logic push;

  assign ready     = !skid_v_r;
  assign push      = push_valid && !skid_v_r;
  assign head_free = !head_v_r || out_ready;
  assign out_valid = head_v_r;
  assign out_rec   = head_r;

  always_comb begin
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    if (head_free) begin
      head_v_nxt = skid_v_r || push;
      skid_v_nxt = 1'b0;
    end else if (push) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (head_free) begin
      head_r <= skid_v_r ? skid_r : push_rec;
    end
    if (push && !head_free) begin
      skid_r <= push_rec;
    end
  end

endmodule

`default_nettype wire

/* hdl/i2c_rtc_register_snooper.sv */
// channel   dir  handshake             payload
// in_       in   in_tvalid/in_tready   tdata: data_byte; tuser: opcode
// out_      out  out_tvalid/out_tready tdata: record fields; tuser: record_kind
// cfg_      in   cfg_we                cfg_index, cfg_wdata
//
// one bus event per cycle sustained while the output stage has room; a result is
// held in the input register, then decoded into the result register
// events that give no result are absorbed with no output
// rst_n is synchronous: phase idle, pointer 0, shadows unset, config to reset
// a two-entry output stage holds results while out_tready is low; in_tready
// drops only once both entries are full
`default_nettype none

module i2c_rtc_register_snooper
  import i2crtc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [6:0]            cfg_wdata,
  // bus event stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // data_byte
  input  wire logic [2:0]            in_tuser,   // opcode
  // record stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // register_index, decoded_value, field_flags, seconds, minutes, hours,
  // weekday, day_of_month, month, year, temperature_q8, zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [3:0]                 out_tuser   // record_kind
);

  item_t in_item, item;
  logic  item_valid;
  logic  eg_ready;
  logic  res_valid;
  rec_t  res, out_rec;

  assign in_item.op        = in_tuser;
  assign in_item.data_byte = in_tdata;

  // input register stage
  i2crtc_ingress u_ingress (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .eg_ready   (eg_ready),
    .item_valid (item_valid),
    .item       (item)
  );

  // phase tracking, pointer, shadows and record build
  i2crtc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result register with skid entry
  i2crtc_egress u_egress (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_rec   (res),
    .ready      (eg_ready),
    .out_valid  (out_tvalid),
    .out_rec    (out_rec),
    .out_ready  (out_tready)
  );

  assign out_tuser = out_rec.kind;
  assign out_tdata = {{(OUT_DATA_W - OUT_USED_W){1'b0}},
                      out_rec.temp, out_rec.year, out_rec.month, out_rec.dom,
                      out_rec.weekday, out_rec.hours, out_rec.minutes,
                      out_rec.seconds, out_rec.flags, out_rec.dval, out_rec.reg_idx};

endmodule

`default_nettype wire

/* hdl/i2crtc_checker.sv */
`default_nettype none

module i2crtc_checker
  import i2crtc_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  cfg_we,
  input wire logic                  cfg_index,
  input wire logic [6:0]            cfg_wdata,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [7:0]            in_tdata,
  input wire logic [2:0]            in_tuser,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [3:0]            out_tuser
);

  // a stalled record holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("record changed while stalled");

  // nothing is shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("record valid after reset");

  // backpressure on events only comes from a waiting record
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("event side stalled with no record waiting");

  // fraction record carries the raw fraction in both places
  a_temp_frac: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == REC_TEMP_FRAC |->
      out_tdata[OFS_TEMP +: 8] == out_tdata[OFS_DVAL +: 8] && !out_tdata[OFS_DVAL + 8])
    else $error("temperature fraction mismatch");

endmodule

bind i2c_rtc_register_snooper i2crtc_checker u_i2crtc_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench;
  import i2crtc_pkg::*;

  // predictor's view of where the snooped transaction stands
  typedef enum logic [2:0] {
    BUS_IDLE,
    BUS_ADDR,
    BUS_SELECT,
    BUS_WRITE,
    BUS_READ
  } bus_phase_e;

  localparam int SETTLE_CYCLES = 6;      // pipeline is two deep, a little margin
  localparam int HOLD_CYCLES   = 400;    // long receiver back-pressure stretch
  localparam int PHASE_EVENTS  = 300;    // random bus events per phase

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       cfg_we = 1'b0;
  logic       cfg_index = CFG_DAY_OFFSET;
  logic [6:0] cfg_wdata = '0;

  logic       in_tvalid = 1'b0;
  wire        in_tready;
  logic [7:0] in_tdata = '0;               // data_byte
  logic [2:0] in_tuser = OP_START;         // opcode

  wire                  out_tvalid;
  logic                 out_tready = 1'b0;
  // register_index, decoded_value, field_flags, seconds, minutes, hours,
  // weekday, day_of_month, month, year, temperature_q8, zero pad
  wire [OUT_DATA_W-1:0] out_tdata;
  wire [3:0]            out_tuser;         // record_kind

  i2c_rtc_register_snooper DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // bus events waiting to be offered, records still owed by the block
  item_t bus_events[$];
  rec_t  due_records[$];

  int errors = 0;
  int stim_count = 0;
  int send_idle = 0;           // percent of cycles the sender holds back
  int recv_idle = 0;           // percent of cycles the receiver holds back
  int hold_req = 0;            // bumped by the stimulus to ask for a long stall
  int hold_seen = 0;
  int hold_left = 0;
  logic [6:0] stim_addr = DEV_ADDR_RST;   // address the stimulus targets

  // ---------------------------------------------------------------------
  // predictor state: own copy of configuration and shadow registers
  // ---------------------------------------------------------------------
  logic [2:0] day_ofs;
  logic [6:0] dev_addr;
  bus_phase_e bus_phase;
  logic [7:0] reg_ptr;
  bit         blk_open;
  shortint    time_regs [7];      // -1 until written
  shortint    temp_regs [2];
  // alarm shadows, shared by both alarms
  bit a_sec_set, a_sec_ign;
  shortint a_sec;
  bit a_min_set, a_min_ign;
  shortint a_min;
  bit a_hr_set, a_hr_12h, a_hr_pm;
  shortint a_hr;
  bit a_day_set, a_day_ign, a_day_mode;
  shortint a_day;

  task automatic flag_error(input string msg);
    errors++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic void clear_shadows();
    day_ofs = 3'd0;
    dev_addr = DEV_ADDR_RST;
    bus_phase = BUS_IDLE;
    reg_ptr = '0;
    blk_open = 1'b0;
    foreach (time_regs[i]) time_regs[i] = -1;
    temp_regs[0] = 0;
    temp_regs[1] = 0;
    {a_sec_set, a_sec_ign, a_min_set, a_min_ign} = '0;
    {a_hr_set, a_hr_12h, a_hr_pm, a_day_set, a_day_ign, a_day_mode} = '0;
    a_sec = 0;
    a_min = 0;
    a_hr = 0;
    a_day = 0;
  endfunction

  function automatic int bcd_val(input logic [7:0] b);
    return b[7:4] * 10 + b[3:0];
  endfunction

  function automatic int weekday_of(input int n);
    return (n + day_ofs) % 7;
  endfunction

  function automatic rec_t blank_rec(input logic [3:0] kind, input int dval, input int flags);
    rec_t r;
    r = '0;
    r.kind = kind;
    r.reg_idx = reg_ptr;
    r.dval = dval;
    r.flags = flags;
    return r;
  endfunction

  // one data byte at the current pointer; pointer auto-increments and wraps
  function automatic bit decode_field(input logic [7:0] b, output rec_t rec);
    logic [7:0] r;
    int val;
    int flags;
    r = reg_ptr;
    val = 0;
    flags = 0;
    rec = '0;
    if (r > REG_TEMP_LSB) begin
      // pointer past the map: byte swallowed, pointer back to zero
      reg_ptr = '0;
      return 1'b0;
    end
    case (r)
      REG_SECONDS, REG_MINUTES, REG_A1_SEC, REG_A1_MIN, REG_A2_MIN: begin
        val = bcd_val(b & 8'h7f);
        flags = b & 8'h80;
        if (r == REG_A1_SEC) begin
          a_sec_set = 1'b1;
          a_sec_ign = b[7];
          a_sec = val;
        end else if (r == REG_A1_MIN || r == REG_A2_MIN) begin
          a_min_set = 1'b1;
          a_min_ign = b[7];
          a_min = val;
        end else begin
          time_regs[r] = val;
        end
      end
      REG_HOURS, REG_A1_HOUR, REG_A2_HOUR: begin
        if (b[6]) begin
          val = bcd_val(b & 8'h1f);
          flags = b & 8'he0;
        end else begin
          val = bcd_val(b & 8'h3f);
          flags = b & 8'hc0;
        end
        if (r == REG_HOURS) begin
          time_regs[2] = val;
        end else if (b[6]) begin
          // 12h alarm hour only lands when not ignored
          if (!b[7]) begin
            a_hr_set = 1'b1;
            a_hr = val;
            a_hr_12h = 1'b1;
            a_hr_pm = b[5];
          end
        end else begin
          // 24h mode drops 12h and pm even when the hour is ignored
          a_hr_12h = 1'b0;
          a_hr_pm = 1'b0;
          if (!b[7]) begin
            a_hr_set = 1'b1;
            a_hr = val;
          end
        end
      end
      REG_DAY: begin
        time_regs[3] = b[2:0];
        val = (b[2:0] != 3'd0) ? weekday_of(b[2:0]) : -1;
        flags = b & 8'hf8;
      end
      REG_DATE: begin
        val = bcd_val(b & 8'h3f);
        flags = b & 8'hc0;
        time_regs[4] = val;
      end
      REG_MONTH: begin
        val = bcd_val(b & 8'h1f);
        flags = b & 8'he0;
        time_regs[5] = val;
      end
      REG_YEAR: begin
        val = bcd_val(b);
        time_regs[6] = val;
      end
      REG_A1_DAY, REG_A2_DAY: begin
        flags = b & 8'hc0;
        a_day_mode = b[6];
        val = b[6] ? weekday_of(b[5:0]) : bcd_val(b & 8'h3f);
        a_day_set = 1'b1;
        a_day_ign = b[7];
        a_day = val;
      end
      REG_CONTROL, REG_STATUS: flags = b;
      REG_AGING: val = $signed(b);
      REG_TEMP_MSB: begin
        val = $signed(b);
        temp_regs[0] = val;
      end
      default: begin
        val = b;
        temp_regs[1] = val;
      end
    endcase
    rec = blank_rec(REC_FIELD, val, flags);
    reg_ptr = (r >= REG_TEMP_LSB) ? 8'd0 : r + 8'd1;
    return 1'b1;
  endfunction

  function automatic bit clock_record(input logic [3:0] kind, output rec_t rec);
    rec = blank_rec(kind, 0, 0);
    // no record while the weekday is zero or was never written
    if (time_regs[3] < 1) return 1'b0;
    rec.seconds = time_regs[0];
    rec.minutes = time_regs[1];
    rec.hours = time_regs[2];
    rec.weekday = weekday_of(time_regs[3]);
    rec.dom = time_regs[4];
    rec.month = time_regs[5];
    rec.year = (time_regs[6] < 0) ? -1 : time_regs[6] + 2000;
    return 1'b1;
  endfunction

  function automatic rec_t alarm_record(input logic [3:0] kind, input bit second_alarm);
    rec_t rec;
    logic [7:0] f;
    f = '0;
    f[0] = !second_alarm && a_sec_ign;
    f[1] = a_min_ign;
    f[2] = a_day_ign;
    f[3] = a_day_mode;
    f[4] = a_hr_12h;
    f[5] = a_hr_pm;
    rec = blank_rec(kind, 0, f);
    rec.seconds = second_alarm ? 0 : (a_sec_set ? a_sec : -1);
    rec.minutes = a_min_set ? a_min : -1;
    rec.hours = a_hr_set ? a_hr : -1;
    if (a_day_set && a_day_mode) begin
      rec.weekday = a_day;
      rec.dom = -1;
    end else begin
      rec.dom = a_day_set ? a_day : -1;
    end
    return rec;
  endfunction

  // signed 8.8: integer byte times 256, plus the raw fraction byte if asked
  function automatic rec_t temp_record(input bit with_frac);
    rec_t rec;
    int q;
    q = temp_regs[0] * 256 + (with_frac ? temp_regs[1] : 0);
    rec = blank_rec(with_frac ? REC_TEMP_FRAC : REC_TEMP_INT,
                    with_frac ? temp_regs[1] : temp_regs[0], 0);
    rec.temp = q;
    return rec;
  endfunction

  // advance the predictor by one bus event; returns 1 when a record is due
  function automatic bit snoop_event(input logic [2:0] op, input logic [7:0] b,
                                     output rec_t rec);
    logic [7:0] r;
    r = reg_ptr;
    rec = '0;
    if (op == OP_STOP) begin
      bus_phase = BUS_IDLE;
      blk_open = 1'b0;
      return 1'b0;
    end
    if (op == OP_START) begin
      bus_phase = BUS_ADDR;
      return 1'b0;
    end
    case (bus_phase)
      BUS_ADDR: begin
        // any other event with a foreign byte drops back to idle
        if (b != {1'b0, dev_addr}) bus_phase = BUS_IDLE;
        else if (op == OP_ADDR_WR) bus_phase = BUS_SELECT;
        else if (op == OP_ADDR_RD) bus_phase = BUS_READ;
      end
      BUS_SELECT: begin
        if (op == OP_DATA_WR) begin
          reg_ptr = b;
          bus_phase = BUS_WRITE;
          rec = blank_rec(REC_SELECT, 0, 0);
          return 1'b1;
        end
        if (op == OP_NACK) bus_phase = BUS_IDLE;
      end
      BUS_WRITE: begin
        if (op == OP_DATA_WR) begin
          if (r == REG_SECONDS || r == REG_A1_SEC || r == REG_A2_MIN) blk_open = 1'b1;
          return decode_field(b, rec);
        end
        if (op == OP_ACK && blk_open) begin
          if (r == REG_A1_SEC) return clock_record(REC_DT_WR, rec);
          if (r == REG_A2_MIN) begin
            rec = alarm_record(REC_AL1_WR, 1'b0);
            return 1'b1;
          end
          if (r == REG_CONTROL) begin
            rec = alarm_record(REC_AL2_WR, 1'b1);
            return 1'b1;
          end
        end
      end
      BUS_READ: begin
        if (op == OP_DATA_RD) begin
          if (r == REG_SECONDS || r == REG_A1_SEC || r == REG_A2_MIN || r == REG_TEMP_MSB)
            blk_open = 1'b1;
          return decode_field(b, rec);
        end
        if (op == OP_NACK && blk_open) begin
          if (r == REG_A1_SEC) return clock_record(REC_DT_RD, rec);
          if (r == REG_A2_MIN) begin
            rec = alarm_record(REC_AL1_RD, 1'b0);
            return 1'b1;
          end
          if (r == REG_CONTROL) begin
            rec = alarm_record(REC_AL2_RD, 1'b1);
            return 1'b1;
          end
          if (r == REG_TEMP_LSB) begin
            rec = temp_record(1'b0);
            return 1'b1;
          end
          if (r == REG_SECONDS) begin
            rec = temp_record(1'b1);
            return 1'b1;
          end
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------
  // predictor process: follows reset, register writes and every input
  // transfer, queueing the record each transfer owes
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : predictor
    rec_t rec;
    if (!rst_n) begin
      clear_shadows();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_DAY_OFFSET) day_ofs = cfg_wdata[2:0];
        else dev_addr = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        if (snoop_event(in_tuser, in_tdata, rec)) due_records.push_back(rec);
      end
    end
  end

  // ---------------------------------------------------------------------
  // driver: offers the next bus event once the current one has transferred,
  // idling at random per send_idle
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : event_driver
    item_t nxt;
    if (rst_n && (!in_tvalid || in_tready)) begin
      if (bus_events.size() != 0 && $urandom_range(99) >= send_idle) begin
        nxt = bus_events.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= nxt.data_byte;
        in_tuser <= nxt.op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready: random stalls, plus a long counted hold when asked
  always @(posedge clk) begin : ready_driver
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // ---------------------------------------------------------------------
  // monitor: unpack each record transfer and check it against the oldest
  // record still owed
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : record_monitor
    rec_t got;
    rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind    = out_tuser;
      got.reg_idx = out_tdata[OFS_REG +: 8];
      got.dval    = out_tdata[OFS_DVAL +: 9];
      got.flags   = out_tdata[OFS_FLAGS +: 8];
      got.seconds = out_tdata[OFS_SEC +: 8];
      got.minutes = out_tdata[OFS_MIN +: 8];
      got.hours   = out_tdata[OFS_HOUR +: 7];
      got.weekday = out_tdata[OFS_WDAY +: 3];
      got.dom     = out_tdata[OFS_DOM +: 7];
      got.month   = out_tdata[OFS_MONTH +: 6];
      got.year    = out_tdata[OFS_YEAR +: 13];
      got.temp    = out_tdata[OFS_TEMP +: 16];
      if (due_records.size() == 0) begin
        flag_error($sformatf("record kind %0d reg %0d with nothing owed",
                             got.kind, got.reg_idx));
      end else begin
        want = due_records.pop_front();
        if (got.kind !== want.kind)
          flag_error($sformatf("kind got %0d want %0d", got.kind, want.kind));
        if (got.reg_idx !== want.reg_idx)
          flag_error($sformatf("register got %0d want %0d", got.reg_idx, want.reg_idx));
        if (got.dval !== want.dval)
          flag_error($sformatf("value got %0d want %0d", got.dval, want.dval));
        if (got.flags !== want.flags)
          flag_error($sformatf("flags got %h want %h", got.flags, want.flags));
        if (got.seconds !== want.seconds)
          flag_error($sformatf("seconds got %0d want %0d", got.seconds, want.seconds));
        if (got.minutes !== want.minutes)
          flag_error($sformatf("minutes got %0d want %0d", got.minutes, want.minutes));
        if (got.hours !== want.hours)
          flag_error($sformatf("hours got %0d want %0d", got.hours, want.hours));
        if (got.weekday !== want.weekday)
          flag_error($sformatf("weekday got %0d want %0d", got.weekday, want.weekday));
        if (got.dom !== want.dom)
          flag_error($sformatf("date got %0d want %0d", got.dom, want.dom));
        if (got.month !== want.month)
          flag_error($sformatf("month got %0d want %0d", got.month, want.month));
        if (got.year !== want.year)
          flag_error($sformatf("year got %0d want %0d", got.year, want.year));
        if (got.temp !== want.temp)
          flag_error($sformatf("temperature got %0d want %0d", got.temp, want.temp));
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------
  function automatic void put_event(input logic [2:0] op, input logic [7:0] b);
    item_t it;
    it.op = op;
    it.data_byte = b;
    bus_events.push_back(it);
    stim_count++;
  endfunction

  // start register: mostly block heads, sometimes anywhere, rarely off the map
  function automatic logic [7:0] pick_reg();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 15) return REG_SECONDS;
    if (sel < 25) return REG_A1_SEC;
    if (sel < 35) return REG_A2_MIN;
    if (sel < 42) return REG_CONTROL;
    if (sel < 52) return REG_TEMP_MSB;
    if (sel < 58) return REG_TEMP_LSB;
    if (sel < 93) return $urandom_range(18);
    return $urandom_range(255);
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 8) return 8'h00;
    if (sel < 16) return 8'hff;
    return $urandom_range(255);
  endfunction

  // our chip's address, now and then someone else's
  function automatic logic [7:0] addr_byte();
    if ($urandom_range(19) == 0) return $urandom_range(255);
    return {1'b0, stim_addr};
  endfunction

  // burst length: usually chosen so the pointer ends on a block boundary
  function automatic int burst_len(input logic [7:0] first);
    int target;
    int n;
    if (first > REG_TEMP_LSB || $urandom_range(9) < 3) return 1 + $urandom_range(21);
    case ($urandom_range(4))
      0: target = REG_A1_SEC;
      1: target = REG_A2_MIN;
      2: target = REG_CONTROL;
      3: target = REG_TEMP_LSB;
      default: target = REG_SECONDS;
    endcase
    n = (target + 19 - first) % 19;
    return (n == 0) ? 19 : n;
  endfunction

  function automatic void write_burst();
    logic [7:0] first;
    int n;
    first = pick_reg();
    n = burst_len(first);
    put_event(OP_START, 8'h00);
    put_event(OP_ADDR_WR, addr_byte());
    put_event(OP_ACK, 8'h00);
    put_event(OP_DATA_WR, first);
    put_event(OP_ACK, 8'h00);
    repeat (n) begin
      put_event(OP_DATA_WR, pick_byte());
      put_event(OP_ACK, 8'h00);
    end
    // sometimes no stop, so the next burst runs on a repeated start
    if ($urandom_range(4) != 0) put_event(OP_STOP, 8'h00);
  endfunction

  function automatic void read_burst();
    logic [7:0] first;
    int n;
    first = pick_reg();
    n = burst_len(first);
    // pointer set by a short write, or left where the last access put it
    if ($urandom_range(3) != 0) begin
      put_event(OP_START, 8'h00);
      put_event(OP_ADDR_WR, addr_byte());
      put_event(OP_ACK, 8'h00);
      put_event(OP_DATA_WR, first);
      put_event(OP_ACK, 8'h00);
    end
    put_event(OP_START, 8'h00);
    put_event(OP_ADDR_RD, addr_byte());
    put_event(OP_ACK, 8'h00);
    for (int i = 0; i < n; i++) begin
      put_event(OP_DATA_RD, pick_byte());
      if (i < n - 1) put_event(OP_ACK, 8'h00);
    end
    put_event(OP_NACK, 8'h00);
    if ($urandom_range(4) != 0) put_event(OP_STOP, 8'h00);
  endfunction

  // stray events with random codes and bytes
  function automatic void line_noise();
    repeat (1 + $urandom_range(5))
      put_event($urandom_range(7),
                ($urandom_range(3) == 0) ? {1'b0, stim_addr} : $urandom_range(255));
  endfunction

  task automatic random_traffic(input int budget);
    int stop_at;
    int unsigned sel;
    stop_at = stim_count + budget;
    while (stim_count < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 45) write_burst();
      else if (sel < 85) read_burst();
      else line_noise();
    end
  endtask

  // sender pauses until every owed record has transferred, then lets the
  // block finish any event that owes nothing
  task automatic settle();
    do @(negedge clk);
    while (bus_events.size() != 0 || in_tvalid || due_records.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [6:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // day offset in the low bits, junk above that the block must ignore
  task automatic set_day_offset(input logic [2:0] ofs);
    write_cfg(CFG_DAY_OFFSET, {4'($urandom_range(15)), ofs});
  endtask

  task automatic set_dev_addr(input logic [6:0] a);
    write_cfg(CFG_DEV_ADDR, a);
    stim_addr = a;
  endtask

  // ---------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles often-ish, receiver mostly stalled
    send_idle = 29;
    recv_idle = 88;
    set_day_offset(3'd0);
    set_dev_addr(DEV_ADDR_RST);
    @(negedge clk);

    // directed: protocol corner cases with default settings
    put_event(OP_ACK, 8'hff);                      // ignored while idle
    put_event(OP_START, 8'h00);
    put_event(OP_ADDR_WR, 8'h69);                  // foreign address
    put_event(OP_START, 8'h00);
    put_event(OP_DATA_RD, 8'h68);                  // matching byte, stays put
    put_event(OP_ADDR_WR, 8'h68);
    put_event(OP_NACK, 8'h00);                     // nack on register select
    put_event(OP_START, 8'h00);
    put_event(OP_ADDR_WR, 8'h68);
    put_event(OP_DATA_WR, 8'hff);                  // select off the map
    put_event(OP_DATA_WR, 8'h00);                  // swallowed, pointer wraps
    put_event(OP_DATA_WR, 8'h59);                  // seconds, opens block
    put_event(OP_START, 8'h00);
    put_event(OP_ADDR_WR, 8'h68);
    put_event(OP_DATA_WR, 8'h04);
    put_event(OP_DATA_WR, 8'hff);
    put_event(OP_DATA_WR, 8'h92);
    put_event(OP_DATA_WR, 8'h99);
    put_event(OP_ACK, 8'h00);                      // weekday never set: no record
    put_event(OP_STOP, 8'h00);
    put_event(OP_START, 8'h00);
    put_event(OP_ADDR_RD, 8'h68);
    put_event(OP_DATA_RD, 8'h00);
    put_event(OP_NACK, 8'h00);                     // not on a boundary
    put_event(OP_STOP, 8'h00);
    settle();

    set_day_offset(3'd3);
    @(negedge clk);
    random_traffic(PHASE_EVENTS);
    settle();

    // roles swapped, lowest address, top legal weekday offset
    send_idle = 88;
    recv_idle = 29;
    set_day_offset(3'd6);
    set_dev_addr(7'h00);
    @(negedge clk);
    random_traffic(PHASE_EVENTS);
    settle();

    // full rate, offset seven folds to zero, highest address; a long
    // receiver hold up front backs the block up into its input
    send_idle = 0;
    recv_idle = 0;
    set_day_offset(3'd7);
    set_dev_addr(7'h7f);
    @(negedge clk);
    hold_req++;
    random_traffic(PHASE_EVENTS);
    settle();

    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

/* i2c_rtc_register_snooper.f */
hdl/i2crtc_pkg.sv
hdl/i2crtc_ingress.sv
hdl/i2crtc_field.sv
hdl/i2crtc_core.sv
hdl/i2crtc_egress.sv
hdl/i2c_rtc_register_snooper.sv
hdl/i2crtc_checker.sv
tb/testbench.sv
